// ----- sv/teseq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// teseq_pkg
// Shared constants for the terminal escape sequence decoder: key codes,
// byte codes and sizes of the recorded-byte store.
// ----------------------------------------------------------------------------
package teseq_pkg;

  localparam int SEEN_MAX = 16;
  localparam int SEEN_AW  = $clog2(SEEN_MAX);
  localparam int SEEN_CW  = $clog2(SEEN_MAX + 1);

  typedef logic [3:0] kind_t;

  localparam kind_t K_UP      = 4'd0;
  localparam kind_t K_DOWN    = 4'd1;
  localparam kind_t K_RIGHT   = 4'd2;
  localparam kind_t K_LEFT    = 4'd3;
  localparam kind_t K_HOME    = 4'd4;
  localparam kind_t K_END     = 4'd5;
  localparam kind_t K_BACKTAB = 4'd6;
  localparam kind_t K_DEL     = 4'd7;
  localparam kind_t K_PGUP    = 4'd8;
  localparam kind_t K_PGDN    = 4'd9;
  localparam kind_t K_META    = 4'd10;
  localparam kind_t K_ALT     = 4'd11;
  localparam kind_t K_UNKNOWN = 4'd12;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] FIN_LO   = 8'h40;
  localparam logic [7:0] FIN_HI   = 8'h7E;
  localparam logic [7:0] BODY_LO  = 8'h20;
  localparam logic [7:0] BODY_HI  = 8'h3F;

endpackage
`default_nettype wire

// ----- sv/terminal_escape_sequence_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// terminal_escape_sequence_decoder
// Decodes the bytes that follow an ESC into key transactions.
//
// Input stream: s_tdata carries one terminal byte, s_tuser flags a timeout
// (byte ignored). Output stream: m_tdata carries the value byte, m_tuser the
// key kind and a value-valid flag, m_tlast closes the run of one input.
// A decoded key or Meta/Alt byte appears on the output register in the
// cycle after its input transaction; a byte that only extends a sequence
// gives no output. An unknown sequence is replayed from the 16-entry byte
// store byte by byte: a store read, then an output load that waits for a
// free output. One input is in flight at a time; s_tready is low while a
// run drains or while a finished result waits on m_tready, and a stalled
// output holds its transaction.
// Reset (rst, synchronous) returns to the after-ESC state with an empty
// store and no output pending; no clearing pass is needed.
// ----------------------------------------------------------------------------
module terminal_escape_sequence_decoder (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,   // [7:0] byte_req
  input  wire        s_tuser,   // [0] timeout
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata,   // [7:0] value
  output logic [4:0] m_tuser,   // [3:0] kind, [4] value_valid
  output logic       m_tlast
);
  import teseq_pkg::*;

  typedef enum logic [1:0] {MODE_ESC, MODE_CSI, MODE_SS3} mode_t;
  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EMIT} state_t;

  logic [7:0]         seen_mem [SEEN_MAX];
  logic [7:0]         rdata;

  mode_t              mode, mode_next;
  state_t             state;
  logic [1:0]         body_count, body_count_next;
  logic [SEEN_CW-1:0] seen_count, seen_count_next;
  logic [7:0]         body_first, body_first_next;
  logic [SEEN_AW-1:0] idx;
  logic [SEEN_CW-1:0] run_len, run_len_next;

  logic               emit, drain, we;
  kind_t              o_kind;
  logic [7:0]         o_value;
  logic               o_vv;
  logic [SEEN_AW-1:0] waddr;
  logic [7:0]         wdata;

  logic               accept, out_free, rec_ok, out_load;
  logic [7:0]         b;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign b        = s_tdata;
  assign rec_ok   = seen_count < SEEN_CW'(SEEN_MAX);
  assign out_load = (accept && emit) || (state == ST_EMIT && out_free);

  always_comb begin
    emit            = 1'b0;
    drain           = 1'b0;
    we              = 1'b0;
    o_kind          = K_UNKNOWN;
    o_value         = 8'h00;
    o_vv            = 1'b0;
    waddr           = seen_count[SEEN_AW-1:0];
    wdata           = b;
    mode_next       = mode;
    body_count_next = body_count;
    seen_count_next = seen_count;
    body_first_next = body_first;
    run_len_next    = seen_count;
    case (mode)
      MODE_SS3: begin
        if (s_tuser) begin
          emit = 1'b1; o_kind = K_META; o_value = CH_O; o_vv = 1'b1;
        end else begin
          emit = 1'b1;
          case (b)
            8'h41:   o_kind = K_UP;
            8'h42:   o_kind = K_DOWN;
            8'h43:   o_kind = K_RIGHT;
            8'h44:   o_kind = K_LEFT;
            8'h48:   o_kind = K_HOME;
            8'h46:   o_kind = K_END;
            default: begin
              // 'O' already sits in entry 0
              emit         = 1'b0;
              drain        = 1'b1;
              we           = 1'b1;
              waddr        = SEEN_AW'(1);
              run_len_next = SEEN_CW'(2);
            end
          endcase
        end
      end
      MODE_CSI: begin
        if (s_tuser) begin
          if (body_count == 2'd0) begin
            emit = 1'b1; o_kind = K_META; o_value = CH_LBRK; o_vv = 1'b1;
          end else begin
            drain = 1'b1;
          end
        end else if (b >= BODY_LO && b <= BODY_HI) begin
          if (body_count != 2'd3) body_count_next = body_count + 2'd1;
          if (body_count == 2'd0) body_first_next = b;
          if (rec_ok) begin
            we              = 1'b1;
            seen_count_next = seen_count + SEEN_CW'(1);
          end
        end else begin
          if (b >= FIN_LO && b <= FIN_HI) begin
            if (body_count == 2'd0) begin
              emit = 1'b1;
              case (b)
                8'h41:   o_kind = K_UP;
                8'h42:   o_kind = K_DOWN;
                8'h43:   o_kind = K_RIGHT;
                8'h44:   o_kind = K_LEFT;
                8'h46:   o_kind = K_END;
                8'h48:   o_kind = K_HOME;
                8'h5A:   o_kind = K_BACKTAB;
                default: emit = 1'b0;
              endcase
            end else if (body_count == 2'd1 && b == CH_TILDE) begin
              emit = 1'b1;
              case (body_first)
                8'h31, 8'h37: o_kind = K_HOME;
                8'h34, 8'h38: o_kind = K_END;
                8'h33:        o_kind = K_DEL;
                8'h35:        o_kind = K_PGUP;
                8'h36:        o_kind = K_PGDN;
                default:      emit = 1'b0;
              endcase
            end
          end
          if (!emit) begin
            drain = 1'b1;
            if (rec_ok) begin
              we           = 1'b1;
              run_len_next = seen_count + SEEN_CW'(1);
            end
          end
        end
      end
      default: begin
        if (s_tuser) begin
          emit = 1'b1;
        end else if (b == CH_ESC) begin
          emit = 1'b0;
        end else if (b == CH_LBRK) begin
          we              = 1'b1;
          waddr           = '0;
          mode_next       = MODE_CSI;
          seen_count_next = SEEN_CW'(1);
        end else if (b == CH_O) begin
          we        = 1'b1;
          waddr     = '0;
          mode_next = MODE_SS3;
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
          emit = 1'b1; o_kind = K_ALT; o_value = b - CH_ZERO; o_vv = 1'b1;
        end else begin
          emit = 1'b1; o_kind = K_META; o_value = b; o_vv = 1'b1;
        end
      end
    endcase
    if (emit || drain) begin
      mode_next       = MODE_ESC;
      body_count_next = 2'd0;
      seen_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && we) seen_mem[waddr] <= wdata;
    rdata <= seen_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mode       <= MODE_ESC;
      body_count <= 2'd0;
      seen_count <= '0;
      m_tvalid   <= 1'b0;
      idx        <= '0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            mode       <= mode_next;
            body_count <= body_count_next;
            seen_count <= seen_count_next;
            body_first <= body_first_next;
            if (emit) begin
              m_tdata  <= o_value;
              m_tuser  <= {o_vv, o_kind};
              m_tlast  <= 1'b1;
            end
            if (drain) begin
              run_len <= run_len_next;
              idx     <= '0;
              state   <= ST_READ;
            end
          end
        end
        ST_READ: state <= ST_EMIT;
        ST_EMIT: begin
          if (out_free) begin
            m_tdata  <= rdata;
            m_tuser  <= {1'b1, K_UNKNOWN};
            m_tlast  <= ({1'b0, idx} + SEEN_CW'(1)) == run_len;
            if (({1'b0, idx} + SEEN_CW'(1)) == run_len) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + SEEN_AW'(1);
              state <= ST_READ;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- verif/tb_terminal_escape_sequence_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_terminal_escape_sequence_decoder
// Self-checking bench for the escape sequence decoder. A queue of terminal
// bytes and timeouts (a directed opening, then mostly well-formed SS3/CSI
// sequences with random content plus noise) feeds a clocked stream driver.
// A behavioral decoder predicts every key transaction on acceptance, and a
// monitor checks each output transaction field by field in order. Both
// stream sides stall in short random bursts, quiet near the end of the run.
// ----------------------------------------------------------------------------
module tb_terminal_escape_sequence_decoder;
  import teseq_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 325;
  localparam int CALM_ITEMS = 40;

  localparam logic [7:0] CH_A = "A";
  localparam logic [7:0] CH_B = "B";
  localparam logic [7:0] CH_C = "C";
  localparam logic [7:0] CH_D = "D";
  localparam logic [7:0] CH_F = "F";
  localparam logic [7:0] CH_H = "H";
  localparam logic [7:0] CH_Z = "Z";
  localparam logic [7:0] CH_1 = "1";
  localparam logic [7:0] CH_3 = "3";
  localparam logic [7:0] CH_4 = "4";
  localparam logic [7:0] CH_5 = "5";
  localparam logic [7:0] CH_6 = "6";
  localparam logic [7:0] CH_7 = "7";
  localparam logic [7:0] CH_8 = "8";
  localparam logic [7:0] CH_SEMI = ";";
  localparam logic [7:0] CH_DEL  = 8'h7F;

  typedef enum logic [1:0] {ST_ESC, ST_CSI, ST_SS3} esc_state_t;

  typedef struct {
    logic [7:0] b;
    logic       tmo;
    bit         hold;
  } term_input_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       vv;
    logic       last;
  } key_event_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [4:0] m_tuser;
  logic       m_tlast;

  terminal_escape_sequence_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  term_input_t pend_inputs[$];
  key_event_t  want_keys[$];
  int          n_want = 0;
  int          n_seen = 0;
  int          errors = 0;
  bit          calm = 1'b0;

  // decoder shadow state
  esc_state_t  sh_mode = ST_ESC;
  logic [1:0]  sh_body = 2'd0;
  logic [7:0]  sh_seen [SEEN_MAX];
  int          sh_seen_n = 0;

  function automatic void seq_clear();
    sh_mode = ST_ESC;
    sh_body = 2'd0;
    sh_seen_n = 0;
  endfunction

  function automatic void seq_note(logic [7:0] b);
    if (sh_seen_n < SEEN_MAX) begin
      sh_seen[sh_seen_n] = b;
      sh_seen_n++;
    end
  endfunction

  function automatic void key_push(kind_t k, logic [7:0] v, logic vv);
    want_keys.push_back('{kind: k, value: v, vv: vv, last: 1'b1});
    n_want++;
    seq_clear();
  endfunction

  function automatic void seq_replay();
    if (sh_seen_n == 0) begin
      key_push(K_UNKNOWN, 8'h00, 1'b0);
    end else begin
      for (int i = 0; i < sh_seen_n; i++) begin
        want_keys.push_back('{kind: K_UNKNOWN, value: sh_seen[i], vv: 1'b1,
                              last: (i == sh_seen_n - 1)});
        n_want++;
      end
      seq_clear();
    end
  endfunction

  function automatic bit cursor_key(logic [7:0] b, output kind_t k);
    cursor_key = 1'b1;
    k = K_UP;
    case (b)
      CH_A: k = K_UP;
      CH_B: k = K_DOWN;
      CH_C: k = K_RIGHT;
      CH_D: k = K_LEFT;
      CH_H: k = K_HOME;
      CH_F: k = K_END;
      default: cursor_key = 1'b0;
    endcase
  endfunction

  function automatic bit tilde_key(logic [7:0] d, output kind_t k);
    tilde_key = 1'b1;
    k = K_HOME;
    case (d)
      CH_1, CH_7: k = K_HOME;
      CH_4, CH_8: k = K_END;
      CH_3: k = K_DEL;
      CH_5: k = K_PGUP;
      CH_6: k = K_PGDN;
      default: tilde_key = 1'b0;
    endcase
  endfunction

  function automatic void decode_predict(logic [7:0] b, logic tmo);
    kind_t k;
    case (sh_mode)
      ST_CSI: begin
        if (tmo) begin
          if (sh_body == 2'd0) key_push(K_META, CH_LBRK, 1'b1);
          else seq_replay();
        end else if (b >= FIN_LO && b <= FIN_HI) begin
          if (sh_body == 2'd0 && cursor_key(b, k)) begin
            key_push(k, 8'h00, 1'b0);
          end else if (sh_body == 2'd0 && b == CH_Z) begin
            key_push(K_BACKTAB, 8'h00, 1'b0);
          end else if (sh_body == 2'd1 && b == CH_TILDE && sh_seen_n >= 2 &&
                       tilde_key(sh_seen[1], k)) begin
            key_push(k, 8'h00, 1'b0);
          end else begin
            seq_note(b);
            seq_replay();
          end
        end else if (b >= BODY_LO && b <= BODY_HI) begin
          if (sh_body != 2'd3) sh_body++;
          seq_note(b);
        end else begin
          seq_note(b);
          seq_replay();
        end
      end
      ST_SS3: begin
        if (tmo) begin
          key_push(K_META, CH_O, 1'b1);
        end else if (cursor_key(b, k)) begin
          key_push(k, 8'h00, 1'b0);
        end else begin
          seq_note(CH_O);
          seq_note(b);
          seq_replay();
        end
      end
      default: begin
        sh_seen_n = 0;
        sh_body = 2'd0;
        if (tmo) begin
          seq_replay();
        end else if (b == CH_LBRK) begin
          seq_note(b);
          sh_mode = ST_CSI;
        end else if (b == CH_O) begin
          sh_mode = ST_SS3;
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
          key_push(K_ALT, b - CH_ZERO, 1'b1);
        end else if (b != CH_ESC) begin
          key_push(K_META, b, 1'b1);
        end
      end
    endcase
  endfunction

  // stimulus helpers
  function automatic void put_byte(logic [7:0] b, bit hold = 1'b0);
    pend_inputs.push_back('{b: b, tmo: 1'b0, hold: hold});
  endfunction

  function automatic void put_timeout(bit hold = 1'b0);
    pend_inputs.push_back('{b: 8'($urandom_range(0, 255)), tmo: 1'b1, hold: hold});
  endfunction

  function automatic logic [7:0] pick_cursor(bit with_z);
    logic [7:0] keys [7];
    keys = '{CH_A, CH_B, CH_C, CH_D, CH_F, CH_H, CH_Z};
    return keys[$urandom_range(0, with_z ? 6 : 5)];
  endfunction

  function automatic logic [7:0] pick_bad();
    if ($urandom_range(0, 1)) return 8'($urandom_range(8'h00, 8'h1F));
    return 8'($urandom_range(8'h7F, 8'hFF));
  endfunction

  function automatic int random_sequence();
    int sel;
    int len;
    bit hold;
    sel = $urandom_range(0, 99);
    hold = ($urandom_range(0, 39) == 0);
    if (sel < 10) begin
      case ($urandom_range(0, 2))
        0: put_timeout(hold);
        1: put_byte(CH_ESC, hold);
        default: put_byte(8'($urandom_range(0, 255)), hold);
      endcase
      return 1;
    end else if (sel < 18) begin
      put_byte(8'($urandom_range(CH_ZERO, CH_NINE)), hold);
      return 1;
    end else if (sel < 33) begin
      put_byte(CH_O, hold);
      case ($urandom_range(0, 4))
        0: put_timeout();
        1: put_byte(8'($urandom_range(0, 255)));
        default: put_byte(pick_cursor(1'b0));
      endcase
      return 2;
    end else if (sel < 50) begin
      put_byte(CH_LBRK, hold);
      if ($urandom_range(0, 3) == 0) put_byte(8'($urandom_range(FIN_LO, FIN_HI)));
      else put_byte(pick_cursor(1'b1));
      return 2;
    end else if (sel < 70) begin
      put_byte(CH_LBRK, hold);
      put_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
      if ($urandom_range(0, 4) == 0) put_byte(8'($urandom_range(FIN_LO, FIN_HI)));
      else put_byte(CH_TILDE);
      return 3;
    end else if (sel < 90) begin
      if ($urandom_range(0, 4) == 0) len = $urandom_range(12, 20);
      else len = $urandom_range(0, 4);
      put_byte(CH_LBRK, hold);
      for (int i = 0; i < len; i++) put_byte(8'($urandom_range(BODY_LO, BODY_HI)));
      case ($urandom_range(0, 3))
        0: put_timeout();
        1: put_byte(pick_bad());
        default: put_byte(8'($urandom_range(FIN_LO, FIN_HI)));
      endcase
      return len + 2;
    end else begin
      if ($urandom_range(0, 3) == 0) put_timeout(hold);
      else put_byte(8'($urandom_range(0, 255)), hold);
      return 1;
    end
  endfunction

  // input driver
  term_input_t on_bus;
  int          send_gap = 0;
  int          drv_cyc = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      s_tuser  <= 1'b0;
      send_gap = 0;
    end else begin
      drv_cyc++;
      if (s_tvalid && s_tready) decode_predict(on_bus.b, on_bus.tmo);
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pend_inputs.size() != 0 &&
                     !(pend_inputs[0].hold && n_want != n_seen)) begin
          on_bus = pend_inputs.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= on_bus.b;
          s_tuser  <= on_bus.tmo;
          if (!calm && (drv_cyc % 250) < 170 && $urandom_range(0, 4) == 0)
            send_gap = $urandom_range(1, 3);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      calm <= (pend_inputs.size() < CALM_ITEMS);
    end
  end

  // output monitor
  key_event_t exp_key;
  int         sink_stall = 0;
  int         mon_cyc = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      mon_cyc++;
      if (m_tvalid && m_tready) begin
        n_seen <= n_seen + 1;
        if (want_keys.size() == 0) begin
          $error("unexpected transaction: kind %0d value %0h", m_tuser[3:0], m_tdata);
          errors++;
        end else begin
          exp_key = want_keys.pop_front();
          if (m_tuser[3:0] !== exp_key.kind) begin
            $error("kind: expected %0d, got %0d", exp_key.kind, m_tuser[3:0]);
            errors++;
          end
          if (m_tdata !== exp_key.value) begin
            $error("value: expected %0h, got %0h", exp_key.value, m_tdata);
            errors++;
          end
          if (m_tuser[4] !== exp_key.vv) begin
            $error("value_valid: expected %0b, got %0b", exp_key.vv, m_tuser[4]);
            errors++;
          end
          if (m_tlast !== exp_key.last) begin
            $error("last: expected %0b, got %0b", exp_key.last, m_tlast);
            errors++;
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_tready <= 1'b0;
      end else if (!calm && (mon_cyc % 300) < 200 && $urandom_range(0, 3) == 0) begin
        sink_stall = $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("terminal_escape_sequence_decoder verification failed");
        $finish;
      end
    end
  end

  initial begin
    int n_rand;
    // empty unknown, skipped ESC, alt digits, meta extremes
    put_timeout();
    put_byte(CH_ESC);
    put_byte(CH_ZERO);
    put_byte(CH_NINE);
    put_byte(8'hFF);
    // SS3: key, timeout as meta, unknown pair
    put_byte(CH_O);
    put_byte(CH_A);
    put_byte(CH_O);
    put_timeout();
    put_byte(CH_O);
    put_byte(8'h00);
    // CSI: backtab, bare timeout, tilde key, timeout mid body, bad byte
    put_byte(CH_LBRK);
    put_byte(CH_Z);
    put_byte(CH_LBRK);
    put_timeout();
    put_byte(CH_LBRK);
    put_byte(CH_5);
    put_byte(CH_TILDE);
    put_byte(CH_LBRK);
    put_byte(CH_1);
    put_byte(CH_SEMI);
    put_timeout();
    put_byte(CH_LBRK);
    put_byte(CH_DEL);
    // drain fully before the random part
    put_byte(CH_LBRK, 1'b1);
    put_byte(CH_B);
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) n_rand += random_sequence();

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pend_inputs.size() != 0 || s_tvalid || want_keys.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && want_keys.size() == 0) begin
      $display("terminal_escape_sequence_decoder verification clean");
    end else begin
      $display("terminal_escape_sequence_decoder verification failed");
    end
    $finish;
  end

endmodule

// ----- terminal_escape_sequence_decoder.f -----
sv/teseq_pkg.sv
sv/terminal_escape_sequence_decoder.sv
verif/tb_terminal_escape_sequence_decoder.sv
